/* design/mtr_pkg.sv */
// Shared types and constants of the Modbus TCP read responder.
// No dependencies; every other file of the block but mtr_if imports this package.
`timescale 1ns / 1ps

package mtr_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 8192;

   localparam int REQ_LEN   = 12;
   localparam int ADDR_W    = 16;
   localparam int ITEM_W    = 11;
   localparam int CMD_DEPTH = 4;

   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_COIL = 2'd1;
   localparam logic [1:0] MODE_REG  = 2'd2;

   localparam logic [7:0] FC_RD_COILS = 8'd1;
   localparam logic [7:0] FC_RD_REGS  = 8'd3;
   localparam logic [7:0] EXC_FLAG    = 8'h80;

   localparam logic [7:0] EXC_BAD_FUNC = 8'd1;
   localparam logic [7:0] EXC_BAD_ADDR = 8'd2;
   localparam logic [7:0] EXC_BAD_QTY  = 8'd3;

   localparam logic [15:0] MAX_COILS = 16'd2000;
   localparam logic [15:0] MAX_REGS  = 16'd125;
   localparam logic [15:0] BASE_LEN  = 16'd3;

   typedef enum logic [2:0] {
      OP_WR_COIL = 3'd0,
      OP_WR_REG  = 3'd1,
      OP_EXC     = 3'd2,
      OP_RD_COIL = 3'd3,
      OP_RD_REG  = 3'd4
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [15:0]       tid;
      logic [7:0]        unit;
      logic [7:0]        fc;
      logic [7:0]        exc;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       value;
   } cmd_type;

endpackage

/* design/mtr_if.sv */
// Handshake channels of the responder: request items in, response words out.
// Depends on nothing; valid and ready move one transaction per edge.
`timescale 1ns / 1ps

interface mtr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  rx_byte;
   logic        frame_end;
   logic [12:0] store_addr;
   logic [15:0] store_value;

   modport source (output valid, mode, rx_byte, frame_end, store_addr, store_value,
                   input ready);
   modport sink   (input valid, mode, rx_byte, frame_end, store_addr, store_value,
                   output ready);
endinterface

interface mtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] tx_data;
   logic [3:0]  tx_count;
   logic        tx_last;

   modport source (output valid, tx_data, tx_count, tx_last, input ready);
   modport sink   (input valid, tx_data, tx_count, tx_last, output ready);
endinterface

/* design/mtr_front.sv */
// Front end: collects request bytes, classifies a finished frame, and forwards
// store writes and frame commands to the queue. Depends on mtr_pkg and mtr_if.
`timescale 1ns / 1ps

module mtr_front import mtr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   mtr_req_if.sink  req,
   input  logic     back_live,
   output logic     cmd_valid,
   input  logic     cmd_ready,
   output cmd_type  cmd
);

   logic [7:0] bytes_ff [REQ_LEN];
   logic [3:0] pos_ff, pos_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       pend_ff, pend_in;

   logic        accept;
   logic [3:0]  pos_next;
   logic [7:0]  fc;
   logic [15:0] start, qty, limit;
   logic [16:0] span;
   logic        cls_valid;
   op_type      cls_op;
   logic [7:0]  cls_exc;
   logic        wr_ok;

   assign req.ready = back_live && !pend_ff && cmd_ready;
   assign accept    = req.valid && req.ready;
   assign pos_next  = (pos_ff < 4'(REQ_LEN)) ? pos_ff + 4'd1 : pos_ff;

   assign fc    = bytes_ff[7];
   assign start = {bytes_ff[8], bytes_ff[9]};
   assign qty   = {bytes_ff[10], bytes_ff[11]};
   assign limit = (fc == FC_RD_COILS) ? MAX_COILS : MAX_REGS;
   assign span  = {1'b0, start} + {1'b0, qty};
   assign wr_ok = {4'd0, req.store_addr} < 17'(TABLE_DEPTH);

   always_comb begin
      cls_valid = 1'b1;
      cls_op    = OP_EXC;
      cls_exc   = EXC_BAD_FUNC;
      priority if (cnt_ff < 4'd8) begin
         cls_valid = 1'b0;
      end else if (bytes_ff[2] != 8'd0 || bytes_ff[3] != 8'd0) begin
         cls_valid = 1'b0;
      end else if (fc != FC_RD_COILS && fc != FC_RD_REGS) begin
         cls_exc = EXC_BAD_FUNC;
      end else if (cnt_ff < 4'(REQ_LEN)) begin
         cls_valid = 1'b0;
      end else if (qty == 16'd0 || qty > limit) begin
         cls_exc = EXC_BAD_QTY;
      end else if (span > 17'(TABLE_DEPTH)) begin
         cls_exc = EXC_BAD_ADDR;
      end else begin
         cls_op = (fc == FC_RD_COILS) ? OP_RD_COIL : OP_RD_REG;
      end
   end

   always_comb begin
      cmd = '{op: cls_op, tid: {bytes_ff[0], bytes_ff[1]}, unit: bytes_ff[6], fc: fc,
              exc: cls_exc, addr: start, value: qty};
      cmd_valid = 1'b0;
      if (pend_ff) begin
         cmd_valid = cls_valid;
      end else begin
         cmd.op    = (req.mode == MODE_COIL) ? OP_WR_COIL : OP_WR_REG;
         cmd.addr  = {3'd0, req.store_addr};
         cmd.value = req.store_value;
         cmd_valid = accept && wr_ok && (req.mode == MODE_COIL || req.mode == MODE_REG);
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      cnt_in  = cnt_ff;
      pend_in = pend_ff;
      if (pend_ff && (!cls_valid || cmd_ready)) begin
         pend_in = 1'b0;
      end
      if (accept && req.mode == MODE_BYTE) begin
         pos_in = pos_next;
         if (req.frame_end) begin
            pos_in  = 4'd0;
            cnt_in  = pos_next;
            pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.mode == MODE_BYTE && pos_ff < 4'(REQ_LEN)) begin
         bytes_ff[pos_ff] <= req.rx_byte;
      end
      if (reset) begin
         pos_ff  <= 4'd0;
         cnt_ff  <= 4'd0;
         pend_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         pend_ff <= pend_in;
      end
   end

endmodule

/* design/mtr_fifo.sv */
// Short command queue between front and back end.
// Depends on mtr_pkg for the command type and depth.
`timescale 1ns / 1ps

module mtr_fifo import mtr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int PTR_W = $clog2(CMD_DEPTH);

   cmd_type          slot_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != (PTR_W+1)'(CMD_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == PTR_W'(CMD_DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == PTR_W'(CMD_DEPTH-1)) ? '0 : rd_ff + 1'b1;
         fill_ff <= fill_in;
      end
   end

endmodule

/* design/mtr_back.sv */
// Back end: owns the coil and register stores, carries out queued writes and
// streams response bytes into 8-byte words. Depends on mtr_pkg and mtr_if.
`timescale 1ns / 1ps

module mtr_back import mtr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      cmd_valid,
   output logic      cmd_ready,
   input  cmd_type   cmd,
   output logic      live,
   mtr_rsp_if.source rsp
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [8:0] {
      ST_CLEAR     = 9'b000000001,
      ST_IDLE      = 9'b000000010,
      ST_HDR       = 9'b000000100,
      ST_REG_RD    = 9'b000001000,
      ST_REG_HI    = 9'b000010000,
      ST_REG_LO    = 9'b000100000,
      ST_COIL_RD   = 9'b001000000,
      ST_COIL_ACC  = 9'b010000000,
      ST_COIL_EMIT = 9'b100000000
   } state_type;

   logic        coil_mem [TABLE_DEPTH];
   logic [15:0] reg_mem  [TABLE_DEPTH];
   logic        coil_rd_ff;
   logic [15:0] reg_rd_ff;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [3:0]        hidx_ff, hidx_in;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic [7:0]        acc_ff, acc_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [63:0]       word_ff;
   logic [2:0]        wcnt_ff;
   logic              out_valid_ff;
   logic [63:0]       out_data_ff;
   logic [3:0]        out_count_ff;
   logic              out_last_ff;

   logic              coil_we, reg_we, coil_re, reg_re, coil_wd;
   logic [IDX_W-1:0]  waddr, raddr;
   logic [15:0]       reg_wd;
   logic              emit_ok, emit_v, emit_l;
   logic [7:0]        emit_b;
   logic [15:0]       qty_ext, bc16, len16, rd_pos;
   logic [7:0]        bc;
   logic              is_exc;
   logic [7:0]        hdr_byte;
   logic [63:0]       word_nx;

   assign live      = state_ff != ST_CLEAR;
   assign emit_ok   = !out_valid_ff || rsp.ready;
   assign rsp.valid    = out_valid_ff;
   assign rsp.tx_data  = out_data_ff;
   assign rsp.tx_count = out_count_ff;
   assign rsp.tx_last  = out_last_ff;

   assign is_exc  = cmd_ff.op == OP_EXC;
   assign qty_ext = cmd_ff.value;
   assign bc16    = (cmd_ff.op == OP_RD_COIL) ? (qty_ext + 16'd7) >> 3 : qty_ext << 1;
   assign bc      = bc16[7:0];
   assign len16   = is_exc ? BASE_LEN : BASE_LEN + {8'd0, bc};

   always_comb begin
      unique case (hidx_ff)
         4'd0:    hdr_byte = cmd_ff.tid[15:8];
         4'd1:    hdr_byte = cmd_ff.tid[7:0];
         4'd4:    hdr_byte = len16[15:8];
         4'd5:    hdr_byte = len16[7:0];
         4'd6:    hdr_byte = cmd_ff.unit;
         4'd7:    hdr_byte = is_exc ? (cmd_ff.fc | EXC_FLAG) : cmd_ff.fc;
         4'd8:    hdr_byte = is_exc ? cmd_ff.exc : bc;
         default: hdr_byte = 8'd0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      hidx_in   = hidx_ff;
      item_in   = item_ff;
      acc_in    = acc_ff;
      clr_in    = clr_ff;
      cmd_ready = 1'b0;
      coil_we   = 1'b0;
      reg_we    = 1'b0;
      coil_re   = 1'b0;
      reg_re    = 1'b0;
      waddr     = cmd.addr[IDX_W-1:0];
      coil_wd   = cmd.value[0];
      reg_wd    = cmd.value;
      rd_pos    = cmd_ff.addr + {5'd0, item_ff};
      emit_v    = 1'b0;
      emit_b    = hdr_byte;
      emit_l    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            coil_we = 1'b1;
            reg_we  = 1'b1;
            waddr   = clr_ff;
            coil_wd = 1'b0;
            reg_wd  = 16'd0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(TABLE_DEPTH-1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_WR_COIL: coil_we = 1'b1;
                  OP_WR_REG:  reg_we  = 1'b1;
                  default: begin
                     cmd_in   = cmd;
                     hidx_in  = 4'd0;
                     item_in  = '0;
                     acc_in   = 8'd0;
                     state_in = ST_HDR;
                  end
               endcase
            end
         end
         ST_HDR: begin
            if (emit_ok) begin
               emit_v = 1'b1;
               emit_l = is_exc && hidx_ff == 4'd8;
               if (hidx_ff == 4'd8) begin
                  state_in = is_exc ? ST_IDLE
                           : (cmd_ff.op == OP_RD_COIL) ? ST_COIL_RD : ST_REG_RD;
               end else begin
                  hidx_in = hidx_ff + 4'd1;
               end
            end
         end
         ST_REG_RD: begin
            reg_re   = 1'b1;
            state_in = ST_REG_HI;
         end
         ST_REG_HI: begin
            emit_b = reg_rd_ff[15:8];
            if (emit_ok) begin
               emit_v   = 1'b1;
               state_in = ST_REG_LO;
            end
         end
         ST_REG_LO: begin
            emit_b = reg_rd_ff[7:0];
            if (emit_ok) begin
               emit_v   = 1'b1;
               emit_l   = {5'd0, item_ff} == qty_ext - 16'd1;
               item_in  = item_ff + 1'b1;
               state_in = emit_l ? ST_IDLE : ST_REG_RD;
            end
         end
         ST_COIL_RD: begin
            coil_re  = 1'b1;
            state_in = ST_COIL_ACC;
         end
         ST_COIL_ACC: begin
            acc_in[item_ff[2:0]] = coil_rd_ff;
            item_in = item_ff + 1'b1;
            if (item_ff[2:0] == 3'd7 || {5'd0, item_ff} == qty_ext - 16'd1) begin
               state_in = ST_COIL_EMIT;
            end else begin
               coil_re = 1'b1;
               rd_pos  = cmd_ff.addr + {5'd0, item_in};
            end
         end
         ST_COIL_EMIT: begin
            emit_b = acc_ff;
            if (emit_ok) begin
               emit_v   = 1'b1;
               emit_l   = {5'd0, item_ff} == qty_ext;
               acc_in   = 8'd0;
               state_in = emit_l ? ST_IDLE : ST_COIL_RD;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      raddr = rd_pos[IDX_W-1:0];
   end

   always_comb begin
      word_nx = word_ff;
      word_nx[{3'd7 - wcnt_ff, 3'b000} +: 8] = emit_b;
   end

   always_ff @(posedge clock) begin
      if (coil_we) coil_mem[waddr] <= coil_wd;
      if (coil_re) coil_rd_ff <= coil_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reg_we) reg_mem[waddr] <= reg_wd;
      if (reg_re) reg_rd_ff <= reg_mem[raddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      hidx_ff <= hidx_in;
      item_ff <= item_in;
      acc_ff  <= acc_in;
      if (emit_v && (wcnt_ff == 3'd7 || emit_l)) begin
         out_data_ff  <= word_nx;
         out_count_ff <= {1'b0, wcnt_ff} + 4'd1;
         out_last_ff  <= emit_l;
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         word_ff      <= 64'd0;
         wcnt_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (emit_v && (wcnt_ff == 3'd7 || emit_l)) begin
            word_ff      <= 64'd0;
            wcnt_ff      <= 3'd0;
            out_valid_ff <= 1'b1;
         end else begin
            if (rsp.ready) out_valid_ff <= 1'b0;
            if (emit_v) begin
               word_ff <= word_nx;
               wcnt_ff <= wcnt_ff + 3'd1;
            end
         end
      end
   end

endmodule

/* design/modbus_tcp_read_responder.sv */
// Modbus TCP responder for Read Coils and Read Holding Registers. After reset
// the block sweeps both stores to zero, one entry a cycle, and takes no item
// until that is done. While a finished frame is classified and handed on,
// no further item is taken. Commands pass a four-entry queue to the back end,
// which sends at most one response byte a cycle: nine header bytes, then for
// each register a store read and its high and low bytes, or for coils a store
// read, an accumulate step per coil and the packed byte, the store read port
// setting that pace. Response words leave through an output register.
// Depends on mtr_pkg, mtr_if, mtr_front, mtr_fifo and mtr_back.
`timescale 1ns / 1ps

module modbus_tcp_read_responder import mtr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   mtr_req_if.sink   req_bus,
   mtr_rsp_if.source rsp_bus
);

   logic    front_valid, front_ready, back_valid, back_ready, back_live;
   cmd_type front_cmd, back_cmd;

   mtr_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .back_live (back_live),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   mtr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   mtr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .live      (back_live),
      .rsp       (rsp_bus)
   );

endmodule
